// ===== sv/rfpw_pkg.sv =====
// Package with sizes, codes and control types for the rotated framebuffer pixel writer.
`timescale 1ns / 1ps

package rfpw_pkg;

  localparam int SCREEN_WIDTH = 400;
  localparam int SCREEN_HEIGHT = 300;
  localparam int STORE_BYTES = 15000;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 9;

  localparam int COORD_MAX = (SCREEN_WIDTH > SCREEN_HEIGHT) ?
                             ((SCREEN_WIDTH > 511) ? SCREEN_WIDTH : 511) :
                             ((SCREEN_HEIGHT > 511) ? SCREEN_HEIGHT : 511);
  localparam int CW = $clog2(COORD_MAX + 1);
  localparam int ADDR_W = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int IDX_W = (2 * CW - 2 > ADDR_W + 1) ? 2 * CW - 2 : ADDR_W + 1;

  localparam logic [8:0] PAGE_WIDTH_RESET = 9'd400;
  localparam logic [8:0] PAGE_HEIGHT_RESET = 9'd300;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ROTATION      = 3'd0,
    REG_PAGED_MODE    = 3'd1,
    REG_PAGE_ORIGIN_X = 3'd2,
    REG_PAGE_ORIGIN_Y = 3'd3,
    REG_PAGE_WIDTH    = 3'd4,
    REG_PAGE_HEIGHT   = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAP,
    ST_OFFSET,
    ST_MULT,
    ST_ADDR,
    ST_READ,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic ready;
    logic clear;
    logic map;
    logic offset;
    logic mult;
    logic addr;
    logic read;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic accept;
    logic clear_last;
    logic out_free;
  } status_t;

endpackage

// ===== sv/rfpw_if.sv =====
// Channel interfaces for pixel write transactions and result transactions.
`timescale 1ns / 1ps

interface rfpw_pixel_if;
  logic valid;
  logic ready;
  logic signed [15:0] pixel_x;
  logic signed [15:0] pixel_y;
  logic [15:0] colour;

  modport source (output valid, output pixel_x, output pixel_y, output colour, input ready);
  modport sink (input valid, input pixel_x, input pixel_y, input colour, output ready);
endinterface

interface rfpw_result_if;
  logic valid;
  logic ready;
  logic written;
  logic [13:0] byte_index;
  logic [7:0] byte_value;

  modport source (output valid, output written, output byte_index, output byte_value,
                  input ready);
  modport sink (input valid, input written, input byte_index, input byte_value,
                output ready);
endinterface

// ===== sv/rfpw_ctrl.sv =====
// Sequencer that steps one pixel transaction through the datapath.
`timescale 1ns / 1ps

module rfpw_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  rfpw_pkg::status_t status,
  output rfpw_pkg::cmd_t    cmd
);
  import rfpw_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (status.accept) begin
          state_next = ST_MAP;
        end
      end
      ST_MAP:    state_next = ST_OFFSET;
      ST_OFFSET: state_next = ST_MULT;
      ST_MULT:   state_next = ST_ADDR;
      ST_ADDR:   state_next = ST_READ;
      ST_READ:   state_next = ST_COMMIT;
      ST_COMMIT: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_CLEAR:  cmd.clear = 1'b1;
      ST_IDLE:   cmd.ready = 1'b1;
      ST_MAP:    cmd.map = 1'b1;
      ST_OFFSET: cmd.offset = 1'b1;
      ST_MULT:   cmd.mult = 1'b1;
      ST_ADDR:   cmd.addr = 1'b1;
      ST_READ:   cmd.read = 1'b1;
      ST_COMMIT: cmd.commit = status.out_free;
      default:   cmd = '0;
    endcase
  end

endmodule

// ===== sv/rfpw_datapath.sv =====
// Datapath with configuration, clipping, rotation, indexing, the pixel store and the result register.
`timescale 1ns / 1ps

module rfpw_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [rfpw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rfpw_pkg::CFG_DATA_W-1:0]  cfg_data,
  rfpw_pixel_if.sink                       pixel,
  rfpw_result_if.source                    result,
  input  rfpw_pkg::cmd_t                   cmd,
  output rfpw_pkg::status_t                status
);
  import rfpw_pkg::*;

  logic [1:0] rotation;
  logic       paged_mode;
  logic [8:0] page_origin_x;
  logic [8:0] page_origin_y;
  logic [8:0] page_width;
  logic [8:0] page_height;

  logic signed [15:0] in_x;
  logic signed [15:0] in_y;
  logic               set_bit;

  logic [CW-1:0]       px;
  logic [CW-1:0]       py;
  logic                on_screen;
  logic [CW-1:0]       qx;
  logic [CW-1:0]       qy;
  logic [CW-1:0]       row_width;
  logic                hit;
  logic [2*CW-1:0]     prod;
  logic [IDX_W-1:0]    idx;
  logic [ADDR_W-1:0]   clr_addr;
  logic [7:0]          rd_data;
  logic [7:0]          mem [STORE_BYTES];

  logic                out_valid;
  logic                out_written;
  logic [13:0]         out_index;
  logic [7:0]          out_value;

  logic [15:0]         lw;
  logic [15:0]         lh;
  logic [CW-1:0]       xl;
  logic [CW-1:0]       yl;
  logic [CW-1:0]       px_next;
  logic [CW-1:0]       py_next;
  logic [CW:0]         dx;
  logic [CW:0]         dy;
  logic [IDX_W-1:0]    idx_next;
  logic [7:0]          mask;
  logic [7:0]          new_byte;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [7:0]          mem_wdata;

  assign pixel.ready = cmd.ready;
  assign status.accept = pixel.valid && cmd.ready;
  assign status.clear_last = (clr_addr == ADDR_W'(STORE_BYTES - 1));
  assign status.out_free = !out_valid || result.ready;

  assign result.valid = out_valid;
  assign result.written = out_written;
  assign result.byte_index = out_index;
  assign result.byte_value = out_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation <= 2'd0;
      paged_mode <= 1'b0;
      page_origin_x <= 9'd0;
      page_origin_y <= 9'd0;
      page_width <= PAGE_WIDTH_RESET;
      page_height <= PAGE_HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_ROTATION:      rotation <= cfg_data[1:0];
        REG_PAGED_MODE:    paged_mode <= cfg_data[0];
        REG_PAGE_ORIGIN_X: page_origin_x <= cfg_data;
        REG_PAGE_ORIGIN_Y: page_origin_y <= cfg_data;
        REG_PAGE_WIDTH:    page_width <= cfg_data;
        REG_PAGE_HEIGHT:   page_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    lw = rotation[0] ? 16'(SCREEN_HEIGHT) : 16'(SCREEN_WIDTH);
    lh = rotation[0] ? 16'(SCREEN_WIDTH) : 16'(SCREEN_HEIGHT);
    xl = in_x[CW-1:0];
    yl = in_y[CW-1:0];
    unique case (rotation)
      2'd0: begin
        px_next = xl;
        py_next = yl;
      end
      2'd1: begin
        px_next = CW'(SCREEN_WIDTH - 1) - yl;
        py_next = xl;
      end
      2'd2: begin
        px_next = CW'(SCREEN_WIDTH - 1) - xl;
        py_next = CW'(SCREEN_HEIGHT - 1) - yl;
      end
      2'd3: begin
        px_next = yl;
        py_next = CW'(SCREEN_HEIGHT - 1) - xl;
      end
      default: begin
        px_next = xl;
        py_next = yl;
      end
    endcase
    dx = {1'b0, px} - {1'b0, CW'(page_origin_x)};
    dy = {1'b0, py} - {1'b0, CW'(page_origin_y)};
    idx_next = IDX_W'(qx[CW-1:3]) + IDX_W'(prod[2*CW-1:3]);
    mask = 8'h80 >> qx[2:0];
    new_byte = set_bit ? (rd_data | mask) : (rd_data & ~mask);
  end

  always_ff @(posedge clk) begin
    if (status.accept) begin
      in_x <= pixel.pixel_x;
      in_y <= pixel.pixel_y;
      set_bit <= (pixel.colour == 16'd0);
    end
    if (cmd.map) begin
      px <= px_next;
      py <= py_next;
      on_screen <= !in_x[15] && !in_y[15] && (16'(in_x) < lw) && (16'(in_y) < lh);
    end
    if (cmd.offset) begin
      if (paged_mode) begin
        qx <= dx[CW-1:0];
        qy <= dy[CW-1:0];
        row_width <= CW'(page_width);
        hit <= on_screen && !dx[CW] && !dy[CW] &&
               (dx[CW-1:0] < CW'(page_width)) && (dy[CW-1:0] < CW'(page_height));
      end else begin
        qx <= px;
        qy <= py;
        row_width <= CW'(SCREEN_WIDTH);
        hit <= on_screen;
      end
    end
    if (cmd.mult) begin
      prod <= qy * row_width;
    end
    if (cmd.addr) begin
      idx <= idx_next;
      hit <= hit && (idx_next < IDX_W'(STORE_BYTES));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear && !status.clear_last) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_comb begin
    mem_we = cmd.clear || (cmd.commit && hit);
    mem_waddr = cmd.clear ? clr_addr : idx[ADDR_W-1:0];
    mem_wdata = cmd.clear ? 8'd0 : new_byte;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.read) begin
      rd_data <= mem[idx[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_written <= hit;
      out_index <= hit ? 14'(idx) : 14'd0;
      out_value <= hit ? new_byte : 8'd0;
    end
  end

`ifndef NO_ASSERTIONS
  a_commit_has_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || result.ready))
    else $error("Result committed while the output register was still occupied.");

  a_dropped_is_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_written) |-> (out_index == 14'd0 && out_value == 8'd0))
    else $error("Dropped pixel reported a nonzero index or value.");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |-> !pixel.ready)
    else $error("Pixel input ready during the clearing pass.");

  a_commit_in_store: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && hit) |-> (idx < IDX_W'(STORE_BYTES)))
    else $error("Store write beyond the last byte.");
`endif

endmodule

// ===== sv/rotated_framebuffer_pixel_writer.sv =====
// Top level of the rotated framebuffer pixel writer.
`timescale 1ns / 1ps

// Each pixel write transaction is clipped to the rotated screen, turned into panel
// coordinates, optionally shifted into the page window and then applied to a
// 1-bit-per-pixel byte store by a read-modify-write; one result transaction reports
// the updated byte or a dropped pixel. The sequencer handles one pixel at a time:
// after acceptance a transaction steps through clip and rotate, page offset, row
// multiply, index, store read and store write; a new pixel is taken only once the
// previous result is in the result register; the commit waits while the output stalls.
// After reset a clearing pass writes zero to all 15000 store bytes, one a cycle,
// and no pixel is accepted until the pass ends; configuration writes are
// taken at any time and should be issued only while no pixel is in flight.
module rotated_framebuffer_pixel_writer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [rfpw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rfpw_pkg::CFG_DATA_W-1:0]  cfg_data,
  rfpw_pixel_if.sink                       pixel,
  rfpw_result_if.source                    result
);
  import rfpw_pkg::*;

  cmd_t    cmd;
  status_t status;

  rfpw_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  rfpw_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel     (pixel),
    .result    (result),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// ===== tb/rotated_framebuffer_pixel_writer_tb.sv =====
// Self-checking testbench for the rotated framebuffer pixel writer: directed table, then random phases.
`timescale 1ns / 1ps

module rotated_framebuffer_pixel_writer_tb;
  import rfpw_pkg::*;

  typedef struct packed {
    logic        written;
    logic [13:0] byte_index;
    logic [7:0]  byte_value;
  } byte_update_t;

  typedef struct {
    bit           is_cfg;
    cfg_reg_t     reg_sel;
    int unsigned  cfg_val;
    int           px;
    int           py;
    int unsigned  col;
    bit           has_exp;
    byte_update_t exp;
  } step_t;

  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS = 155;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rfpw_pixel_if pixel_ch();
  rfpw_result_if result_ch();

  rotated_framebuffer_pixel_writer u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .pixel(pixel_ch),
    .result(result_ch)
  );

  logic [7:0] store_mirror [STORE_BYTES];
  logic [1:0] rot_q;
  logic paged_q;
  logic [8:0] ox_q;
  logic [8:0] oy_q;
  logic [8:0] pw_q;
  logic [8:0] ph_q;

  byte_update_t pending_bytes [$];
  step_t plot_table [$];
  int mismatches = 0;
  int results_seen = 0;
  bit sender_burst = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    rst <= 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #6000000;
    $display("[rotated_framebuffer_pixel_writer] ERROR");
    $finish;
  end

  function automatic byte_update_t predict_plot(logic signed [15:0] lx_in,
                                                logic signed [15:0] ly_in,
                                                logic [15:0] col);
    int x;
    int y;
    int t;
    int lw;
    int lh;
    int idx;
    logic [7:0] mask;
    byte_update_t r;
    r = '0;
    x = lx_in;
    y = ly_in;
    lw = (rot_q[0]) ? SCREEN_HEIGHT : SCREEN_WIDTH;
    lh = (rot_q[0]) ? SCREEN_WIDTH : SCREEN_HEIGHT;
    if (x < 0 || x >= lw || y < 0 || y >= lh) return r;
    case (rot_q)
      2'd1: begin
        t = x; x = y; y = t;
        x = SCREEN_WIDTH - x - 1;
      end
      2'd2: begin
        x = SCREEN_WIDTH - x - 1;
        y = SCREEN_HEIGHT - y - 1;
      end
      2'd3: begin
        t = x; x = y; y = t;
        y = SCREEN_HEIGHT - y - 1;
      end
      default: ;
    endcase
    if (paged_q) begin
      x = x - int'(ox_q);
      y = y - int'(oy_q);
      if (x < 0 || x >= int'(pw_q) || y < 0 || y >= int'(ph_q)) return r;
      idx = x / 8 + (y * int'(pw_q)) / 8;
    end else begin
      idx = x / 8 + (y * SCREEN_WIDTH) / 8;
    end
    if (idx >= STORE_BYTES) return r;
    mask = 8'h80 >> (x % 8);
    if (col == 16'd0) store_mirror[idx] = store_mirror[idx] | mask;
    else store_mirror[idx] = store_mirror[idx] & ~mask;
    r.written = 1'b1;
    r.byte_index = idx[13:0];
    r.byte_value = store_mirror[idx];
    return r;
  endfunction

  task automatic write_reg(cfg_reg_t sel, int unsigned val);
    cfg_write <= 1'b1;
    cfg_index <= sel;
    cfg_data <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    case (sel)
      REG_ROTATION:      rot_q = val[1:0];
      REG_PAGED_MODE:    paged_q = val[0];
      REG_PAGE_ORIGIN_X: ox_q = val[8:0];
      REG_PAGE_ORIGIN_Y: oy_q = val[8:0];
      REG_PAGE_WIDTH:    pw_q = val[8:0];
      REG_PAGE_HEIGHT:   ph_q = val[8:0];
      default: ;
    endcase
  endtask

  task automatic send_pixel(int px, int py, int unsigned col, bit has_exp, byte_update_t exp);
    int gap;
    byte_update_t predicted;
    gap = sender_burst ? 0 : $urandom_range(0, 18);
    cfg_write <= 1'b0;
    if (gap > 0) begin
      pixel_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_ch.valid <= 1'b1;
    pixel_ch.pixel_x <= px[15:0];
    pixel_ch.pixel_y <= py[15:0];
    pixel_ch.colour <= col[15:0];
    @(posedge clk);
    while (pixel_ch.ready !== 1'b1) @(posedge clk);
    predicted = predict_plot(px[15:0], py[15:0], col[15:0]);
    pending_bytes.push_back(has_exp ? exp : predicted);
  endtask

  task automatic drain_block();
    pixel_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_bytes.size() > 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic random_coords(output int lx, output int ly);
    int r;
    int px;
    int py;
    int lw;
    int lh;
    int edge_val;
    lw = (rot_q[0]) ? SCREEN_HEIGHT : SCREEN_WIDTH;
    lh = (rot_q[0]) ? SCREEN_WIDTH : SCREEN_HEIGHT;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      if (paged_q) begin
        px = int'(ox_q) - 2 + int'($urandom_range(0, int'(pw_q) + 3));
        py = int'(oy_q) - 2 + int'($urandom_range(0, int'(ph_q) + 3));
      end else begin
        px = $urandom_range(0, SCREEN_WIDTH - 1);
        py = $urandom_range(0, SCREEN_HEIGHT - 1);
      end
      if (px < 0) px = 0;
      if (px > SCREEN_WIDTH - 1) px = SCREEN_WIDTH - 1;
      if (py < 0) py = 0;
      if (py > SCREEN_HEIGHT - 1) py = SCREEN_HEIGHT - 1;
      case (rot_q)
        2'd1: begin lx = py; ly = SCREEN_WIDTH - 1 - px; end
        2'd2: begin lx = SCREEN_WIDTH - 1 - px; ly = SCREEN_HEIGHT - 1 - py; end
        2'd3: begin lx = SCREEN_HEIGHT - 1 - py; ly = px; end
        default: begin lx = px; ly = py; end
      endcase
    end else if (r < 85) begin
      lx = $urandom_range(0, lw - 1);
      ly = $urandom_range(0, lh - 1);
      case ($urandom_range(0, 5))
        0: edge_val = -1;
        1: edge_val = 0;
        2: edge_val = lw - 1;
        3: edge_val = lw;
        4: edge_val = -32768;
        default: edge_val = 32767;
      endcase
      if ($urandom_range(0, 1)) lx = edge_val;
      else ly = (edge_val == lw - 1) ? lh - 1 : (edge_val == lw) ? lh : edge_val;
    end else begin
      lx = int'($signed($urandom_range(0, 65535) - 32768));
      ly = int'($signed($urandom_range(0, 65535) - 32768));
    end
  endtask

  task automatic add_cfg(cfg_reg_t sel, int unsigned val);
    step_t s;
    s = '{reg_sel: REG_ROTATION, default: '0};
    s.is_cfg = 1'b1;
    s.reg_sel = sel;
    s.cfg_val = val;
    plot_table.push_back(s);
  endtask

  task automatic add_pix(int px, int py, int unsigned col, bit has_exp,
                         logic w, int unsigned idx, int unsigned val);
    step_t s;
    s = '{reg_sel: REG_ROTATION, default: '0};
    s.px = px;
    s.py = py;
    s.col = col;
    s.has_exp = has_exp;
    s.exp = '{written: w, byte_index: idx[13:0], byte_value: val[7:0]};
    plot_table.push_back(s);
  endtask

  initial begin
    int stall;
    bit long_hold_done;
    byte_update_t got;
    byte_update_t want;
    long_hold_done = 0;
    forever begin
      if (!long_hold_done && results_seen == 500) begin
        stall = 300;
        long_hold_done = 1;
      end else if ((results_seen % 600) >= 450) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 18);
      end
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (result_ch.valid !== 1'b1) @(posedge clk);
      got = '{written: result_ch.written, byte_index: result_ch.byte_index,
              byte_value: result_ch.byte_value};
      results_seen++;
      if (pending_bytes.size() == 0) begin
        $display("%0t: result transaction with nothing expected: %s%0b index=%0d value=%02h",
                 $time, "written=", got.written, got.byte_index, got.byte_value);
        mismatches++;
      end else begin
        want = pending_bytes.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch: expected written=%0b index=%0d value=%02h,",
                   $time, want.written, want.byte_index, want.byte_value,
                   " got written=%0b index=%0d value=%02h",
                   got.written, got.byte_index, got.byte_value);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int lx;
    int ly;
    int unsigned col;
    bit last_was_pixel;
    byte_update_t none;
    none = '0;
    cfg_write <= 1'b0;
    cfg_index <= REG_ROTATION;
    cfg_data <= '0;
    pixel_ch.valid <= 1'b0;
    pixel_ch.pixel_x <= '0;
    pixel_ch.pixel_y <= '0;
    pixel_ch.colour <= '0;
    for (int i = 0; i < STORE_BYTES; i++) store_mirror[i] = 8'h00;
    rot_q = 2'd0;
    paged_q = 1'b0;
    ox_q = '0;
    oy_q = '0;
    pw_q = PAGE_WIDTH_RESET;
    ph_q = PAGE_HEIGHT_RESET;

    add_pix(0, 0, 0, 1, 1, 0, 8'h80);
    add_pix(399, 299, 0, 1, 1, 14999, 8'h01);
    add_pix(7, 0, 0, 1, 1, 0, 8'h81);
    add_pix(0, 0, 16'hFFFF, 1, 1, 0, 8'h01);
    add_pix(-32768, -32768, 0, 1, 0, 0, 0);
    add_pix(32767, 32767, 16'hFFFF, 1, 0, 0, 0);
    add_pix(400, 0, 0, 1, 0, 0, 0);
    add_pix(0, 300, 0, 1, 0, 0, 0);
    add_pix(-1, 5, 0, 1, 0, 0, 0);
    add_cfg(REG_ROTATION, 1);
    add_pix(299, 399, 0, 0, 0, 0, 0);
    add_pix(300, 0, 0, 1, 0, 0, 0);
    add_pix(0, 399, 16'h8000, 0, 0, 0, 0);
    add_cfg(REG_ROTATION, 2);
    add_pix(0, 0, 0, 0, 0, 0, 0);
    add_pix(399, 299, 1, 0, 0, 0, 0);
    add_cfg(REG_ROTATION, 3);
    add_pix(0, 0, 0, 0, 0, 0, 0);
    add_pix(299, 400, 0, 1, 0, 0, 0);
    add_cfg(REG_ROTATION, 0);
    add_cfg(REG_PAGED_MODE, 1);
    add_cfg(REG_PAGE_ORIGIN_X, 8);
    add_cfg(REG_PAGE_ORIGIN_Y, 10);
    add_cfg(REG_PAGE_WIDTH, 16);
    add_cfg(REG_PAGE_HEIGHT, 4);
    add_pix(8, 10, 0, 0, 0, 0, 0);
    add_pix(7, 10, 0, 1, 0, 0, 0);
    add_pix(24, 10, 0, 1, 0, 0, 0);
    add_pix(8, 14, 0, 1, 0, 0, 0);
    add_cfg(REG_PAGE_WIDTH, 13);
    add_pix(20, 12, 0, 0, 0, 0, 0);
    add_cfg(REG_PAGE_WIDTH, 0);
    add_pix(8, 10, 0, 1, 0, 0, 0);
    add_cfg(REG_PAGE_WIDTH, 400);
    add_cfg(REG_PAGE_HEIGHT, 0);
    add_pix(8, 10, 0, 1, 0, 0, 0);
    add_cfg(REG_PAGE_WIDTH, 511);
    add_cfg(REG_PAGE_HEIGHT, 300);
    add_cfg(REG_PAGE_ORIGIN_X, 0);
    add_cfg(REG_PAGE_ORIGIN_Y, 0);
    add_pix(399, 299, 0, 1, 0, 0, 0);
    add_pix(0, 20, 0, 0, 0, 0, 0);

    while (rst !== 1'b0) @(posedge clk);

    last_was_pixel = 0;
    foreach (plot_table[i]) begin
      if (plot_table[i].is_cfg) begin
        if (last_was_pixel) drain_block();
        write_reg(plot_table[i].reg_sel, plot_table[i].cfg_val);
        last_was_pixel = 0;
      end else begin
        send_pixel(plot_table[i].px, plot_table[i].py, plot_table[i].col,
                   plot_table[i].has_exp, plot_table[i].exp);
        last_was_pixel = 1;
      end
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain_block();
      sender_burst = (p % 4 == 2);
      write_reg(REG_ROTATION, p % 4);
      write_reg(REG_PAGED_MODE, p % 2);
      case (p)
        1: begin
          write_reg(REG_PAGE_ORIGIN_X, 0);
          write_reg(REG_PAGE_ORIGIN_Y, 0);
          write_reg(REG_PAGE_WIDTH, 400);
          write_reg(REG_PAGE_HEIGHT, 300);
        end
        3: begin
          write_reg(REG_PAGE_ORIGIN_X, 399);
          write_reg(REG_PAGE_ORIGIN_Y, 299);
          write_reg(REG_PAGE_WIDTH, 8);
          write_reg(REG_PAGE_HEIGHT, 1);
        end
        5: begin
          write_reg(REG_PAGE_ORIGIN_X, $urandom_range(0, 399));
          write_reg(REG_PAGE_ORIGIN_Y, $urandom_range(0, 299));
          write_reg(REG_PAGE_WIDTH, 8 * $urandom_range(1, 49) + $urandom_range(1, 7));
          write_reg(REG_PAGE_HEIGHT, $urandom_range(1, 300));
        end
        7: begin
          write_reg(REG_PAGE_ORIGIN_X, 0);
          write_reg(REG_PAGE_ORIGIN_Y, 0);
          write_reg(REG_PAGE_WIDTH, 511);
          write_reg(REG_PAGE_HEIGHT, 511);
        end
        11: begin
          write_reg(REG_PAGE_ORIGIN_X, $urandom_range(0, 399));
          write_reg(REG_PAGE_ORIGIN_Y, $urandom_range(0, 299));
          write_reg(REG_PAGE_WIDTH, 8 * $urandom_range(1, 50));
          write_reg(REG_PAGE_HEIGHT, 0);
        end
        default: begin
          write_reg(REG_PAGE_ORIGIN_X, $urandom_range(0, 399));
          write_reg(REG_PAGE_ORIGIN_Y, $urandom_range(0, 299));
          write_reg(REG_PAGE_WIDTH, 8 * $urandom_range(1, 50));
          write_reg(REG_PAGE_HEIGHT, $urandom_range(1, 300));
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        random_coords(lx, ly);
        col = $urandom_range(0, 1) ? 0 : $urandom_range(0, 65535);
        send_pixel(lx, ly, col, 0, none);
      end
    end
    sender_burst = 0;
    drain_block();

    if (mismatches == 0) begin
      $display("[rotated_framebuffer_pixel_writer] OK");
    end else begin
      $display("[rotated_framebuffer_pixel_writer] ERROR");
    end
    $finish;
  end

endmodule
